>>> rtl/pid_reciprocal_integral_assert.svh
// ----------------------------------------------------------------------------
// pid_reciprocal_integral assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_RECIPROCAL_INTEGRAL_ASSERT_SVH
`define PID_RECIPROCAL_INTEGRAL_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PRI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_reciprocal_integral: assertion failed");
// next-cycle implication
`define PRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_reciprocal_integral: assertion failed");
`else
`define PRI_ASSERT_IMPL(lbl, ante, cons)
`define PRI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/pri_pkg.sv
// ----------------------------------------------------------------------------
// pri_pkg
// Shared widths, register codes and serial-unit handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pri_pkg;

  localparam int DATA_W = 32;
  localparam int ERR_W  = 33;
  localparam int SUM_W  = 48;
  localparam int LIM_W  = 47;
  localparam int MC_W   = 111;
  localparam int MP_W   = 47;
  localparam int DVD_W  = 89;
  localparam int DVS_W  = 42;
  localparam int STEP_W = 7;
  localparam int TOT_W  = 96;
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // Q.16 numerator of the reciprocal term (100.0)
  localparam logic [22:0] RECIP_NUM = 23'd6553600;
  localparam logic [DVS_W-1:0] DIV_TEN = 42'd10;

  // serial step counts per operation
  localparam logic [STEP_W-1:0] STEPS_RECIP = 7'd23;
  localparam logic [STEP_W-1:0] STEPS_WORD  = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_P     = 7'd65;
  localparam logic [STEP_W-1:0] STEPS_I     = 7'd71;
  localparam logic [STEP_W-1:0] STEPS_D     = 7'd89;

  // register reset values
  localparam logic [DATA_W-1:0] RST_PERIOD = 32'd16777;
  localparam logic [DATA_W-1:0] RST_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] RST_MAX    = 32'h7FFF_FFFF;
  localparam logic [LIM_W-1:0]  RST_LIMIT  = 47'd65536000000;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_SAMPLE_PERIOD,
    REG_DRIVE_MIN,
    REG_DRIVE_MAX,
    REG_SUM_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } ser_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

  // give an unsigned magnitude its sign in the wide total format
  function automatic logic [TOT_W-1:0] apply_sign(input logic [DVD_W-1:0] mag,
                                                  input logic neg);
    logic [TOT_W-1:0] ext;
    ext = TOT_W'(mag);
    return neg ? (~ext + TOT_W'(1)) : ext;
  endfunction

endpackage

>>> rtl/pri_mul.sv
// ----------------------------------------------------------------------------
// pri_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pri_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pri_pkg::ser_ctl_t           ctl,
  input  logic [pri_pkg::MC_W-1:0]    mcand,
  input  logic [pri_pkg::MP_W-1:0]    mplier,
  output logic [pri_pkg::MC_W-1:0]    prod,
  output pri_pkg::ser_sts_t           sts
);
  import pri_pkg::*;

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [MC_W-1:0]   acc_r, mc_r;
  logic [MP_W-1:0]   mp_r;
  logic [MC_W-1:0]   acc_nxt;

  // add the shifted multiplicand when the current bit is set
  assign acc_nxt = mp_r[0] ? (acc_r + mc_r) : acc_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: load, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
      mc_r  <= mcand;
      mp_r  <= mplier;
      cnt_r <= ctl.steps;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mc_r  <= {mc_r[MC_W-2:0], 1'b0};
      mp_r  <= {1'b0, mp_r[MP_W-1:1]};
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign prod     = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> rtl/pri_div.sv
// ----------------------------------------------------------------------------
// pri_div
// Restoring divider, one quotient bit per cycle; dividend left-aligned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pri_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pri_pkg::ser_ctl_t           ctl,
  input  logic [pri_pkg::DVD_W-1:0]   dividend,
  input  logic [pri_pkg::DVS_W-1:0]   divisor,
  output logic [pri_pkg::DVD_W-1:0]   quot,
  output pri_pkg::ser_sts_t           sts
);
  import pri_pkg::*;

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  q_r;
  logic [DVS_W-1:0]  rem_r, dvs_r;
  logic [DVS_W:0]    trial;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  // trial subtract of the divisor from the shifted remainder
  assign trial   = {rem_r, q_r[DVD_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= ctl.steps;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> rtl/pid_reciprocal_integral.sv
// ----------------------------------------------------------------------------
// pid_reciprocal_integral
// PID position loop, derivative on measurement, reciprocal-error integral.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: target and measured.
//   Result channel (out_valid/out_ready) returns one drive word per input.
//   Gains, sample period, drive limits and the integral clamp are written
//   over the APB-style cfg_ port at byte address 8*index, 64-bit data.
// Sequencing:
//   One word at a time. Eight serial operations run on a shared shift-add
//   multiplier and a shared restoring divider, one bit per cycle:
//   23 + 32 + 65 + 32 + 32 + 71 + 32 + 89 = 376 bit steps; the reciprocal
//   division (23 steps) is skipped when the error is zero.
//   The next word is accepted once the result sits in the output register.
// Reset:
//   Synchronous, active low; clears the integral sum, the last measurement,
//   restores the register defaults and drops out_valid.
// Stall:
//   A stalled result holds in the output register; a finished next result
//   waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_reciprocal_integral_assert.svh"
module pid_reciprocal_integral (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_target,
  input  logic signed [31:0]            in_measured,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_drive,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pri_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [pri_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [pri_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import pri_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_QDIV, S_SUM, S_PMUL, S_PDIV, S_IMUL1, S_IMUL2,
    S_IDIV, S_DMUL, S_DDIV, S_TOT, S_OUT
  } state_t;

  // configuration registers
  logic [DATA_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r, period_r;
  logic [DATA_W-1:0] drive_min_r, drive_max_r;
  logic [LIM_W-1:0]  sum_limit_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      period_r     <= RST_PERIOD;
      drive_min_r  <= RST_MIN;
      drive_max_r  <= RST_MAX;
      sum_limit_r  <= RST_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:     prop_gain_r  <= cfg_pwdata[DATA_W-1:0];
        REG_INTEG_GAIN:    integ_gain_r <= cfg_pwdata[DATA_W-1:0];
        REG_DERIV_GAIN:    deriv_gain_r <= cfg_pwdata[DATA_W-1:0];
        REG_SAMPLE_PERIOD: period_r     <= cfg_pwdata[DATA_W-1:0];
        REG_DRIVE_MIN:     drive_min_r  <= cfg_pwdata[DATA_W-1:0];
        REG_DRIVE_MAX:     drive_max_r  <= cfg_pwdata[DATA_W-1:0];
        REG_SUM_LIMIT:     sum_limit_r  <= cfg_pwdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:     cfg_prdata = CFG_DW'(prop_gain_r);
      REG_INTEG_GAIN:    cfg_prdata = CFG_DW'(integ_gain_r);
      REG_DERIV_GAIN:    cfg_prdata = CFG_DW'(deriv_gain_r);
      REG_SAMPLE_PERIOD: cfg_prdata = CFG_DW'(period_r);
      REG_DRIVE_MIN:     cfg_prdata = CFG_DW'(drive_min_r);
      REG_DRIVE_MAX:     cfg_prdata = CFG_DW'(drive_max_r);
      REG_SUM_LIMIT:     cfg_prdata = CFG_DW'(sum_limit_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // loop state and working registers
  state_t            state_r;
  logic [ERR_W-1:0]  err_r, dm_r;
  logic [DATA_W-1:0] last_r;
  logic [SUM_W-1:0]  sum_r;
  logic [TOT_W-1:0]  p_r, i_r, d_r, tot_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_drive_r;

  ser_ctl_t          mul_ctl_r, div_ctl_r;
  ser_sts_t          mul_sts, div_sts;
  logic [MC_W-1:0]   mul_a_r, mul_prod;
  logic [MP_W-1:0]   mul_b_r;
  logic [DVD_W-1:0]  div_a_r, div_q;
  logic [DVS_W-1:0]  div_b_r;

  pri_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mul_ctl_r),
    .mcand  (mul_a_r),
    .mplier (mul_b_r),
    .prod   (mul_prod),
    .sts    (mul_sts)
  );

  pri_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .quot     (div_q),
    .sts      (div_sts)
  );

  // differences and magnitudes
  logic [ERR_W-1:0]  err_v, dm_v, in_err_mag, err_mag, dm_mag;
  logic [DATA_W-1:0] pg_mag, ig_mag, dg_mag, ts_eff;
  logic [SUM_W-1:0]  sum_neg_v;
  logic [LIM_W-1:0]  sum_mag;
  logic [DVS_W-1:0]  ts_ext, ts1000;

  assign err_v = {in_target[31], in_target} - {in_measured[31], in_measured};
  assign dm_v  = {in_measured[31], in_measured} - {last_r[31], last_r};
  assign in_err_mag = err_v[ERR_W-1] ? (~err_v + ERR_W'(1)) : err_v;
  assign err_mag    = err_r[ERR_W-1] ? (~err_r + ERR_W'(1)) : err_r;
  assign dm_mag     = dm_r[ERR_W-1]  ? (~dm_r + ERR_W'(1))  : dm_r;
  assign pg_mag = prop_gain_r[31]  ? (~prop_gain_r + DATA_W'(1))  : prop_gain_r;
  assign ig_mag = integ_gain_r[31] ? (~integ_gain_r + DATA_W'(1)) : integ_gain_r;
  assign dg_mag = deriv_gain_r[31] ? (~deriv_gain_r + DATA_W'(1)) : deriv_gain_r;
  assign sum_neg_v = ~sum_r + SUM_W'(1);
  assign sum_mag   = sum_r[SUM_W-1] ? sum_neg_v[LIM_W-1:0] : sum_r[LIM_W-1:0];

  // zero period counts as one; period * 1000 = p*1024 - p*32 + p*8
  assign ts_eff = (period_r == '0) ? DATA_W'(1) : period_r;
  assign ts_ext = DVS_W'(ts_eff);
  assign ts1000 = (ts_ext << 10) - (ts_ext << 5) + (ts_ext << 3);

  // integral sum update with clamp
  logic [SUM_W:0]   q_ext, q_sgn, sum_add, lim_p, lim_n, sum_cl;
  logic [SUM_W-1:0] sum_nxt;

  assign q_ext   = (SUM_W+1)'(div_q[22:0]);
  assign q_sgn   = err_r[ERR_W-1] ? (~q_ext + (SUM_W+1)'(1)) : q_ext;
  assign sum_add = {sum_r[SUM_W-1], sum_r} + q_sgn;
  assign lim_p   = (SUM_W+1)'(sum_limit_r);
  assign lim_n   = ~lim_p + (SUM_W+1)'(1);

  always_comb begin
    if ($signed(sum_add) > $signed(lim_p)) begin
      sum_cl = lim_p;
    end else if ($signed(sum_add) < $signed(lim_n)) begin
      sum_cl = lim_n;
    end else begin
      sum_cl = sum_add;
    end
    sum_nxt = (err_r == '0) ? '0 : sum_cl[SUM_W-1:0];
  end

  // output clamp: maximum first, then minimum
  logic [TOT_W-1:0] hi_v, lo_v, clamp_hi, clamp_v;

  assign hi_v     = {{(TOT_W-DATA_W){drive_max_r[31]}}, drive_max_r};
  assign lo_v     = {{(TOT_W-DATA_W){drive_min_r[31]}}, drive_min_r};
  assign clamp_hi = ($signed(tot_r) > $signed(hi_v)) ? hi_v : tot_r;
  assign clamp_v  = ($signed(lo_v) > $signed(clamp_hi)) ? lo_v : clamp_hi;

  // sequencer: state, unit commands and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mul_ctl_r   <= '0;
      div_ctl_r   <= '0;
      last_r      <= '0;
      sum_r       <= '0;
    end else begin
      // raise on handoff, drop once the word is taken
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            err_r  <= err_v;
            dm_r   <= dm_v;
            last_r <= in_measured;
            if (err_v == '0) begin
              state_r <= S_SUM;
            end else begin
              div_a_r   <= {RECIP_NUM, (DVD_W-23)'(0)};
              div_b_r   <= DVS_W'(in_err_mag);
              div_ctl_r <= '{start: 1'b1, steps: STEPS_RECIP};
              state_r   <= S_QDIV;
            end
          end
        end
        S_QDIV: begin
          if (div_sts.done) begin
            state_r <= S_SUM;
          end else begin
            div_ctl_r.start <= 1'b0;
          end
        end
        S_SUM: begin
          sum_r     <= sum_nxt;
          mul_a_r   <= MC_W'(err_mag);
          mul_b_r   <= MP_W'(pg_mag);
          mul_ctl_r <= '{start: 1'b1, steps: STEPS_WORD};
          state_r   <= S_PMUL;
        end
        S_PMUL: begin
          if (mul_sts.done) begin
            div_a_r   <= {mul_prod[64:0], 24'd0};
            div_b_r   <= DIV_TEN;
            div_ctl_r <= '{start: 1'b1, steps: STEPS_P};
            state_r   <= S_PDIV;
          end else begin
            mul_ctl_r.start <= 1'b0;
          end
        end
        S_PDIV: begin
          if (div_sts.done) begin
            p_r       <= apply_sign(div_q, prop_gain_r[31] ^ err_r[ERR_W-1]);
            mul_a_r   <= MC_W'(sum_mag);
            mul_b_r   <= MP_W'(ig_mag);
            mul_ctl_r <= '{start: 1'b1, steps: STEPS_WORD};
            state_r   <= S_IMUL1;
          end else begin
            div_ctl_r.start <= 1'b0;
          end
        end
        S_IMUL1: begin
          if (mul_sts.done) begin
            mul_a_r   <= mul_prod;
            mul_b_r   <= MP_W'(ts_eff);
            mul_ctl_r <= '{start: 1'b1, steps: STEPS_WORD};
            state_r   <= S_IMUL2;
          end else begin
            mul_ctl_r.start <= 1'b0;
          end
        end
        S_IMUL2: begin
          if (mul_sts.done) begin
            div_a_r   <= {mul_prod[110:40], 18'd0};
            div_b_r   <= DIV_TEN;
            div_ctl_r <= '{start: 1'b1, steps: STEPS_I};
            state_r   <= S_IDIV;
          end else begin
            mul_ctl_r.start <= 1'b0;
          end
        end
        S_IDIV: begin
          if (div_sts.done) begin
            i_r       <= apply_sign(div_q, integ_gain_r[31] ^ sum_r[SUM_W-1]);
            mul_a_r   <= MC_W'(dm_mag);
            mul_b_r   <= MP_W'(dg_mag);
            mul_ctl_r <= '{start: 1'b1, steps: STEPS_WORD};
            state_r   <= S_DMUL;
          end else begin
            div_ctl_r.start <= 1'b0;
          end
        end
        S_DMUL: begin
          if (mul_sts.done) begin
            div_a_r   <= {mul_prod[64:0], 24'd0};
            div_b_r   <= ts1000;
            div_ctl_r <= '{start: 1'b1, steps: STEPS_D};
            state_r   <= S_DDIV;
          end else begin
            mul_ctl_r.start <= 1'b0;
          end
        end
        S_DDIV: begin
          if (div_sts.done) begin
            d_r     <= apply_sign(div_q, deriv_gain_r[31] ^ dm_r[ERR_W-1]);
            state_r <= S_TOT;
          end else begin
            div_ctl_r.start <= 1'b0;
          end
        end
        S_TOT: begin
          tot_r   <= p_r + i_r + d_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hand off once the output register is free
          if (!out_valid_r || out_ready) begin
            out_drive_r <= clamp_v[DATA_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // checks
  logic mul_wait_st, div_wait_st, clamp_live;

  assign mul_wait_st = (state_r == S_PMUL) || (state_r == S_IMUL1) ||
                       (state_r == S_IMUL2) || (state_r == S_DMUL);
  assign div_wait_st = (state_r == S_QDIV) || (state_r == S_PDIV) ||
                       (state_r == S_IDIV) || (state_r == S_DDIV);
  assign clamp_live  = (state_r == S_OUT);

  `PRI_ASSERT_IMPL(a_idle_units, state_r == S_IDLE, !mul_sts.busy && !div_sts.busy)
  `PRI_ASSERT_IMPL(a_mul_done_state, mul_sts.done, mul_wait_st)
  `PRI_ASSERT_IMPL(a_div_done_state, div_sts.done, div_wait_st)
  `PRI_ASSERT_IMPL(a_clamp_low, clamp_live, $signed(clamp_v) >= $signed(lo_v))
  `PRI_ASSERT_IMPL(a_clamp_high, clamp_live && ($signed(drive_min_r) <= $signed(drive_max_r)), $signed(clamp_v) <= $signed(hi_v))
  `PRI_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)

endmodule

>>> sim/pid_reciprocal_integral_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_reciprocal_integral_checker
// Watches the input, result and register ports of the PID loop, keeps its
// own copy of the gains, limits and loop state, predicts each drive word
// and compares it with the word that comes out.
// ----------------------------------------------------------------------------
module pid_reciprocal_integral_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [31:0]         in_target,
  input  logic signed [31:0]         in_measured,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [31:0]         out_drive,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pri_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pri_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         fail_count,
  output int                         drives_pending
);
  import pri_pkg::*;

  logic signed [31:0] kp, ki, kd, lim_lo, lim_hi;
  logic [31:0]        period;
  logic [46:0]        sum_clamp;
  logic signed [31:0] prev_meas;
  longint             integ_sum;
  logic [31:0]        drive_q[$];

  // compute one drive word and advance the loop state
  function automatic logic [31:0] next_drive(logic signed [31:0] tgt,
                                             logic signed [31:0] meas);
    logic signed [32:0]  err, dm;
    longint              e64, lim;
    logic [127:0]        a, b, ts, pm, im, dmag;
    logic signed [127:0] sp, si, sd, tot, hi, lo;
    err = tgt - meas;
    dm  = meas - prev_meas;
    e64 = err;
    lim = longint'({17'd0, sum_clamp});
    // reciprocal integral with clamp
    if (err == 0) integ_sum = 0;
    else integ_sum = integ_sum + 64'sd6553600 / e64;
    if (integ_sum > lim) integ_sum = lim;
    else if (integ_sum < -lim) integ_sum = -lim;
    ts = (period == 0) ? 128'd1 : 128'(period);
    // proportional
    a  = kp < 0 ? 128'(-longint'(kp)) : 128'(kp);
    b  = err < 0 ? 128'(-e64) : 128'(e64);
    pm = (a * b) / 10;
    sp = ((kp < 0) != (err < 0)) ? -$signed(pm) : $signed(pm);
    // integral
    a  = ki < 0 ? 128'(-longint'(ki)) : 128'(ki);
    b  = integ_sum < 0 ? 128'(-integ_sum) : 128'(integ_sum);
    im = ((a * b * ts) >> 40) / 10;
    si = ((ki < 0) != (integ_sum < 0)) ? -$signed(im) : $signed(im);
    // derivative on measurement
    a    = kd < 0 ? 128'(-longint'(kd)) : 128'(kd);
    b    = dm < 0 ? 128'(-longint'(dm)) : 128'(longint'(dm));
    dmag = (((a * b) << 24) / ts) / 1000;
    sd   = ((kd < 0) != (dm < 0)) ? -$signed(dmag) : $signed(dmag);
    // sum, then clamp high before low
    tot = sp + si + sd;
    hi  = lim_hi;
    lo  = lim_lo;
    if (tot > hi) tot = hi;
    if (lo > tot) tot = lo;
    prev_meas = meas;
    return tot[31:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      kp = 0; ki = 0; kd = 0;
      period = RST_PERIOD; lim_lo = RST_MIN; lim_hi = RST_MAX;
      sum_clamp = RST_LIMIT; prev_meas = 0; integ_sum = 0;
      drive_q.delete();
      fail_count = 0;
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[5:3]))
          REG_PROP_GAIN:     kp = cfg_pwdata[31:0];
          REG_INTEG_GAIN:    ki = cfg_pwdata[31:0];
          REG_DERIV_GAIN:    kd = cfg_pwdata[31:0];
          REG_SAMPLE_PERIOD: period = cfg_pwdata[31:0];
          REG_DRIVE_MIN:     lim_lo = cfg_pwdata[31:0];
          REG_DRIVE_MAX:     lim_hi = cfg_pwdata[31:0];
          REG_SUM_LIMIT:     sum_clamp = cfg_pwdata[46:0];
          default: ;
        endcase
      end
      // compare the drive word against the oldest prediction
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          $error("drive: unexpected word %0d", out_drive);
          fail_count++;
        end else begin
          logic [31:0] exp_drive;
          exp_drive = drive_q.pop_front();
          if (out_drive !== exp_drive) begin
            $error("drive: expected %0d, actual %0d", $signed(exp_drive), out_drive);
            fail_count++;
          end
        end
      end
      // predict on each accepted word
      if (in_valid && in_ready) drive_q.push_back(next_drive(in_target, in_measured));
    end
    drives_pending = drive_q.size();
  end

endmodule

>>> sim/pid_reciprocal_integral_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_reciprocal_integral_test
// Drives the PID loop through several register settings with directed and
// random target/measured words under random sender gaps and receiver stalls;
// the checker predicts and compares every drive word.
// ----------------------------------------------------------------------------
module pid_reciprocal_integral_test;
  import pri_pkg::*;

  logic                clk, rst_n;
  logic                in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0]  in_target, in_measured, out_drive;
  logic                cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata, cfg_prdata;
  int                  fail_count, drives_pending;
  int                  cycles;
  logic                rx_started;
  logic signed [31:0]  walk_pos;

  pid_reciprocal_integral dut (.*);

  pid_reciprocal_integral_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // guard against a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("FAIL pid_reciprocal_integral");
        $finish;
      end
    end
  end

  // receiver: one long hold-off, then randomly chosen free and stalling stretches
  initial begin
    int mode;
    out_ready = 0;
    wait (rx_started);
    repeat (4000) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 600)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= CFG_AW'(idx) << 3; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // hold the word until accepted
  task automatic send_word(logic [31:0] tgt, logic [31:0] meas);
    in_valid <= 1; in_target <= tgt; in_measured <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
  endtask

  // settle all registers for one phase
  task automatic set_regs(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                          logic [31:0] ts, logic [31:0] lo, logic [31:0] hi,
                          logic [46:0] sl);
    reg_write(REG_PROP_GAIN, 64'(p));
    reg_write(REG_INTEG_GAIN, 64'(i));
    reg_write(REG_DERIV_GAIN, 64'(d));
    reg_write(REG_SAMPLE_PERIOD, 64'(ts));
    reg_write(REG_DRIVE_MIN, 64'(lo));
    reg_write(REG_DRIVE_MAX, 64'(hi));
    reg_write(REG_SUM_LIMIT, 64'(sl));
  endtask

  // mostly a tracking loop with small errors, some full-range noise
  task automatic random_words(int n);
    int burst;
    logic [31:0] tgt;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        case ($urandom_range(0, 9))
          0, 1: send_word($urandom, $urandom);
          2: send_word(walk_pos, walk_pos);
          default: begin
            walk_pos = walk_pos + $signed(32'($urandom_range(0, 400)) - 200);
            tgt = walk_pos + $signed(32'($urandom_range(0, 2000)) - 1000);
            send_word(tgt, walk_pos);
          end
        endcase
        burst--; n--;
      end
      in_valid <= 0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  initial begin
    in_valid = 0; in_target = 0; in_measured = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    rx_started = 0; walk_pos = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults first, then typical gains
    send_word(32'd100, 32'd0);
    rx_started <= 1;
    send_word(32'd5, 32'd5);
    send_word(32'd9, 32'd4);
    drain();
    set_regs(32'h0001_8000, 32'h0000_4000, 32'h0002_0000, 32'd16777,
             32'hFFF0_0000, 32'h0010_0000, 47'd65536000000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'd1, 32'd0);
    send_word(32'd0, 32'd1);
    send_word(32'd7, 32'd7);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h0000_0000, 32'h8000_0000);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);
    send_word(32'h5555_5555, 32'hAAAA_AAAA);
    send_word(32'd3, 32'd2);
    drain();
    // extreme gains, zero sample period, inverted limits
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
             32'h0000_1000, 32'hFFFF_0000, 47'h7FFF_FFFF_FFFF);
    send_word(32'd1, 32'd0);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'd2, 32'd2);
    drain();
    set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 47'd0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'd1, 32'd0);
    send_word(32'd9, 32'd9);
    send_word(32'hFFFF_FFFF, 32'd1);
    drain();

    // random phases
    set_regs(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'd16777,
             32'hFF00_0000, 32'h0100_0000, 47'd65536000000);
    random_words(120);
    drain();
    set_regs($urandom, $urandom, $urandom, $urandom, 32'h8000_0000,
             32'h7FFF_FFFF, 47'({$urandom, $urandom}));
    random_words(120);
    drain();
    set_regs($urandom, $urandom, $urandom, 32'd1, 32'h8000_0000,
             32'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF);
    random_words(120);
    drain();
    set_regs(32'h0000_2000, 32'h0040_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
             32'hFFFF_F000, 32'h0000_F000, 47'd6553600);
    random_words(120);
    drain();
    set_regs($urandom, $urandom, $urandom, $urandom_range(1, 1000000),
             $urandom, $urandom, 47'($urandom_range(0, 65536000)));
    random_words(120);
    drain();
    set_regs($urandom, $urandom, $urandom, $urandom, 32'h8000_0000,
             32'h7FFF_FFFF, 47'({$urandom, $urandom}));
    random_words(125);
    drain();

    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS pid_reciprocal_integral");
    end else begin
      $display("FAIL pid_reciprocal_integral");
    end
    $finish;
  end

endmodule
